// ===== rtl/mstk_pkg.sv =====
// ----------------------------------------------------------------------------
// mstk_pkg
// Shared types, sizes and codes for the Q16.16 4x4 matrix stack.
// ----------------------------------------------------------------------------
package mstk_pkg;

   // stack and matrix sizing
   localparam int STACK_DEPTH = 32;
   localparam int MATRIX_SIZE = 4;

   localparam int ELEM_W     = 32;
   localparam int FRAC_W     = 16;
   localparam int ELEM_CNT   = 16;
   localparam int ELEM_IDX_W = 4;
   localparam int DIM_W      = 2;
   localparam int LVL_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int MEM_DEPTH  = STACK_DEPTH * ELEM_CNT;
   localparam int MEM_ADDR_W = LVL_W + ELEM_IDX_W;
   localparam int ACC_W      = 2 * ELEM_W + $clog2(MATRIX_SIZE) + 1;

   localparam logic [DIM_W-1:0] MS_LAST  = DIM_W'(MATRIX_SIZE - 1);
   localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(STACK_DEPTH - 1);
   localparam logic [ELEM_IDX_W-1:0] IDX_LAST = ELEM_IDX_W'(ELEM_CNT - 1);

   localparam logic [ELEM_W-1:0] ONE_Q16  = 32'h0001_0000;
   localparam logic [ELEM_W-1:0] ELEM_MAX = 32'h7FFF_FFFF;
   localparam logic [ELEM_W-1:0] ELEM_MIN = 32'h8000_0000;
   localparam logic [FRAC_W-1:0] FRAC_MASK = 16'hFFFF;

   // request codes
   localparam int REQ_TYPE_W = 3;
   localparam logic [REQ_TYPE_W-1:0] REQ_IDENTITY = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_PUSH     = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_POP      = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_LOAD     = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ     = 3'd4;

   // status codes
   localparam int STATUS_W = 2;
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

   // control travelling with each multiply-accumulate step
   typedef struct packed {
      logic                  first;
      logic                  last;
      logic [ELEM_IDX_W-1:0] idx;
   } mac_tag_type;

   // finished dot product
   typedef struct packed {
      logic                  valid;
      logic [ELEM_IDX_W-1:0] idx;
   } mac_res_type;

   // identity matrix element at a column-major index
   function automatic logic [ELEM_W-1:0] identity_elem(input logic [ELEM_IDX_W-1:0] idx);
      logic [ELEM_W-1:0] val;
      val = (idx[1:0] == idx[3:2]) ? ONE_Q16 : '0;
      return val;
   endfunction

endpackage

// ===== rtl/mstk_ifs.sv =====
// ----------------------------------------------------------------------------
// mstk_ifs
// Valid/ready channels for stack commands and for result transactions.
// ----------------------------------------------------------------------------
interface mstk_req_if import mstk_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [REQ_TYPE_W-1:0]        req_type;
   logic [ELEM_IDX_W-1:0]        elem_index;
   logic signed [ELEM_W-1:0]     elem_value;

   modport source (output valid, output req_type, output elem_index, output elem_value,
                   input ready);
   modport sink   (input valid, input req_type, input elem_index, input elem_value,
                   output ready);
endinterface

interface mstk_rsp_if import mstk_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [STATUS_W-1:0]          status;
   logic [ELEM_IDX_W-1:0]        out_index;
   logic signed [ELEM_W-1:0]     out_value;
   logic                         last;

   modport source (output valid, output status, output out_index, output out_value,
                   output last, input ready);
   modport sink   (input valid, input status, input out_index, input out_value,
                   input last, output ready);
endinterface

// ===== rtl/mstk_mac.sv =====
// ----------------------------------------------------------------------------
// mstk_mac
// Pipelined Q16.16 multiply-accumulate: operand register, 32x32 multiply,
// wide accumulate, then truncation toward zero and saturation to 32 bits.
// ----------------------------------------------------------------------------
module mstk_mac import mstk_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     issue,
   input  mac_tag_type              issue_tag,
   input  logic signed [ELEM_W-1:0] a_in,
   input  logic signed [ELEM_W-1:0] b_in,
   output mac_res_type              res,
   output logic signed [ELEM_W-1:0] res_value,
   output logic                     busy
);

   localparam int Q_W = ACC_W - FRAC_W;

   logic                       v1_ff, v2_ff, done3_ff, v4_ff;
   mac_tag_type                tag1_ff, tag2_ff;
   logic [ELEM_IDX_W-1:0]      idx3_ff, idx4_ff;
   logic signed [ELEM_W-1:0]   a_ff, b_ff;
   logic signed [2*ELEM_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [ELEM_W-1:0]   sat_ff, sat_in;
   logic signed [ACC_W-1:0]    biased;
   logic signed [Q_W-1:0]      quot;
   logic [Q_W-ELEM_W:0]        upper;

   // accumulate, restarting on the first step of a dot product
   always_comb begin
      acc_in = (tag2_ff.first ? '0 : acc_ff) + ACC_W'(prod_ff);
   end

   // truncate toward zero, then clamp to the 32-bit range
   always_comb begin
      biased = acc_ff + (acc_ff[ACC_W-1] ? ACC_W'(FRAC_MASK) : ACC_W'(0));
      quot   = biased[ACC_W-1:FRAC_W];
      upper  = quot[Q_W-1:ELEM_W-1];
      if (upper == '0 || upper == '1) begin
         sat_in = quot[ELEM_W-1:0];
      end else if (quot[Q_W-1]) begin
         sat_in = ELEM_MIN;
      end else begin
         sat_in = ELEM_MAX;
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         done3_ff <= 1'b0;
         v4_ff    <= 1'b0;
      end else begin
         v1_ff    <= issue;
         v2_ff    <= v1_ff;
         done3_ff <= v2_ff && tag2_ff.last;
         v4_ff    <= done3_ff;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      tag1_ff <= issue_tag;
      prod_ff <= a_ff * b_ff;
      tag2_ff <= tag1_ff;
      if (v2_ff) begin
         acc_ff <= acc_in;
      end
      idx3_ff <= tag2_ff.idx;
      if (done3_ff) begin
         sat_ff <= sat_in;
      end
      idx4_ff <= idx3_ff;
   end

   assign res.valid = v4_ff;
   assign res.idx   = idx4_ff;
   assign res_value = sat_ff;
   assign busy      = v1_ff || v2_ff || done3_ff || v4_ff;

endmodule

// ===== rtl/matrix_stack_multiply.sv =====
// ----------------------------------------------------------------------------
// matrix_stack_multiply
// Stack of 4x4 column-major Q16.16 matrices with identity, push, pop,
// operand load with top-times-operand multiply, and readout of the top.
// ----------------------------------------------------------------------------
// The top matrix lives in registers and the levels beneath it in a
// single-port-write, single-port-read stack memory, so no clearing pass is
// needed after reset: the block is ready as soon as reset is released, with
// identity at the only level. One command is handled at a time. Identity,
// pop/push that are refused, unused codes and operand loads of elements 0-14
// go through the response state to their single result. Push copies the top
// into memory one word a cycle; pop reads the level below back through the
// registered memory port. Read gives 16 results back to back when the sink
// keeps up. Loading element 15 runs the multiply on one shared pipelined
// multiply-accumulate unit: MATRIX_SIZE^3 products issued one a cycle (64
// for 4x4), a drain of the pipeline, a copy of the product back to the top
// and the result. The result register lets a new command be accepted while
// the previous result still waits for the sink.
// ----------------------------------------------------------------------------
module matrix_stack_multiply import mstk_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   mstk_req_if.sink   req_chan,
   mstk_rsp_if.source rsp_chan
);

   localparam int STATE_W = 4;
   localparam logic [STATE_W-1:0] ST_IDLE    = 4'd0;
   localparam logic [STATE_W-1:0] ST_MAC     = 4'd1;
   localparam logic [STATE_W-1:0] ST_DRAIN   = 4'd2;
   localparam logic [STATE_W-1:0] ST_COPY    = 4'd3;
   localparam logic [STATE_W-1:0] ST_PUSH    = 4'd4;
   localparam logic [STATE_W-1:0] ST_POP     = 4'd5;
   localparam logic [STATE_W-1:0] ST_POP_END = 4'd6;
   localparam logic [STATE_W-1:0] ST_RESP    = 4'd7;
   localparam logic [STATE_W-1:0] ST_READ    = 4'd8;

   // control state
   logic [STATE_W-1:0]    state_ff, state_in;
   logic [ELEM_IDX_W-1:0] cnt_ff, cnt_in;
   logic [DIM_W-1:0]      k_ff, k_in, r_ff, r_in, c_ff, c_in;
   logic [LVL_W-1:0]      level_ff, level_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  pop_vld_ff;
   logic [ELEM_IDX_W-1:0] pop_idx_ff;

   // result register
   logic                     out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0]      out_status_ff, out_status_in;
   logic [ELEM_IDX_W-1:0]    out_index_ff, out_index_in;
   logic signed [ELEM_W-1:0] out_value_ff, out_value_in;
   logic                     out_last_ff, out_last_in;
   logic                     out_load;

   // matrix storage
   logic signed [ELEM_W-1:0] top_ff     [ELEM_CNT];
   logic signed [ELEM_W-1:0] opnd_ff    [ELEM_CNT];
   logic signed [ELEM_W-1:0] scratch_ff [ELEM_CNT];
   logic signed [ELEM_W-1:0] stack_mem  [MEM_DEPTH];
   logic signed [ELEM_W-1:0] mem_q_ff;

   logic                     accept, out_free, id_set, copy_we, mem_we;
   logic [ELEM_IDX_W-1:0]    top_rd_addr;
   logic signed [ELEM_W-1:0] top_q;
   logic [LVL_W-1:0]         lvl_dn;
   logic [MEM_ADDR_W-1:0]    mem_wr_addr, mem_rd_addr;

   // multiply-accumulate unit hookup
   logic                     mac_issue, mac_busy;
   mac_tag_type              mac_tag;
   mac_res_type              mac_res;
   logic signed [ELEM_W-1:0] mac_value;

   // handshakes
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !out_valid_ff || rsp_chan.ready;

   // shared read port of the top matrix
   assign top_rd_addr = (state_ff == ST_MAC) ? {k_ff, r_ff} : cnt_ff;
   assign top_q       = top_ff[top_rd_addr];

   // stack memory addressing
   assign lvl_dn      = level_ff - LVL_W'(1);
   assign mem_we      = (state_ff == ST_PUSH);
   assign mem_wr_addr = {level_ff, cnt_ff};
   assign mem_rd_addr = {lvl_dn, cnt_ff};

   // top matrix write enables
   assign id_set  = accept && (req_chan.req_type == REQ_IDENTITY);
   assign copy_we = (state_ff == ST_COPY) && (cnt_ff[1:0] <= MS_LAST)
                    && (cnt_ff[3:2] <= MS_LAST);

   // multiply issue: top row r times operand column c, step k
   assign mac_issue     = (state_ff == ST_MAC);
   assign mac_tag.first = (k_ff == '0);
   assign mac_tag.last  = (k_ff == MS_LAST);
   assign mac_tag.idx   = {c_ff, r_ff};

   mstk_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .issue     (mac_issue),
      .issue_tag (mac_tag),
      .a_in      (top_q),
      .b_in      (opnd_ff[{c_ff, k_ff}]),
      .res       (mac_res),
      .res_value (mac_value),
      .busy      (mac_busy)
   );

   // command sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      k_in          = k_ff;
      r_in          = r_ff;
      c_in          = c_ff;
      level_in      = level_ff;
      status_in     = status_ff;
      out_load      = 1'b0;
      out_status_in = out_status_ff;
      out_index_in  = out_index_ff;
      out_value_in  = out_value_ff;
      out_last_in   = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            cnt_in    = '0;
            k_in      = '0;
            r_in      = '0;
            c_in      = '0;
            status_in = STATUS_OK;
            if (accept) begin
               case (req_chan.req_type)
                  REQ_PUSH: begin
                     if (level_ff == LVL_FULL) begin
                        status_in = STATUS_OVERFLOW;
                        state_in  = ST_RESP;
                     end else begin
                        state_in = ST_PUSH;
                     end
                  end
                  REQ_POP: begin
                     if (level_ff == '0) begin
                        status_in = STATUS_UNDERFLOW;
                        state_in  = ST_RESP;
                     end else begin
                        state_in = ST_POP;
                     end
                  end
                  REQ_LOAD: begin
                     state_in = (req_chan.elem_index == IDX_LAST) ? ST_MAC : ST_RESP;
                  end
                  REQ_READ: begin
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_MAC: begin
            if (k_ff == MS_LAST) begin
               k_in = '0;
               if (c_ff == MS_LAST) begin
                  c_in = '0;
                  if (r_ff == MS_LAST) begin
                     r_in     = '0;
                     state_in = ST_DRAIN;
                  end else begin
                     r_in = r_ff + DIM_W'(1);
                  end
               end else begin
                  c_in = c_ff + DIM_W'(1);
               end
            end else begin
               k_in = k_ff + DIM_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!mac_busy) begin
               cnt_in   = '0;
               state_in = ST_COPY;
            end
         end
         ST_COPY: begin
            cnt_in = cnt_ff + ELEM_IDX_W'(1);
            if (cnt_ff == IDX_LAST) begin
               state_in = ST_RESP;
            end
         end
         ST_PUSH: begin
            cnt_in = cnt_ff + ELEM_IDX_W'(1);
            if (cnt_ff == IDX_LAST) begin
               level_in = level_ff + LVL_W'(1);
               state_in = ST_RESP;
            end
         end
         ST_POP: begin
            cnt_in = cnt_ff + ELEM_IDX_W'(1);
            if (cnt_ff == IDX_LAST) begin
               state_in = ST_POP_END;
            end
         end
         ST_POP_END: begin
            level_in = lvl_dn;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               out_load      = 1'b1;
               out_status_in = status_ff;
               out_index_in  = '0;
               out_value_in  = '0;
               out_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_READ: begin
            if (out_free) begin
               out_load      = 1'b1;
               out_status_in = STATUS_OK;
               out_index_in  = cnt_ff;
               out_value_in  = top_q;
               out_last_in   = (cnt_ff == IDX_LAST);
               cnt_in        = cnt_ff + ELEM_IDX_W'(1);
               if (cnt_ff == IDX_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result valid: set on load, cleared once the sink takes the transaction
   always_comb begin
      out_valid_in = out_load || (out_valid_ff && !rsp_chan.ready);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         k_ff         <= '0;
         r_ff         <= '0;
         c_ff         <= '0;
         level_ff     <= '0;
         status_ff    <= STATUS_OK;
         pop_vld_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         r_ff         <= r_in;
         c_ff         <= c_in;
         level_ff     <= level_in;
         status_ff    <= status_in;
         pop_vld_ff   <= (state_ff == ST_POP);
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      pop_idx_ff    <= cnt_ff;
      out_status_ff <= out_status_in;
      out_index_ff  <= out_index_in;
      out_value_ff  <= out_value_in;
      out_last_ff   <= out_last_in;
   end

   // top matrix: identity after reset and on command, product copy, pop refill
   always_ff @(posedge clock) begin
      if (reset || id_set) begin
         for (int i = 0; i < ELEM_CNT; i++) begin
            top_ff[i] <= identity_elem(ELEM_IDX_W'(i));
         end
      end else begin
         if (copy_we) begin
            top_ff[cnt_ff] <= scratch_ff[cnt_ff];
         end
         if (pop_vld_ff) begin
            top_ff[pop_idx_ff] <= mem_q_ff;
         end
      end
   end

   // operand buffer and product scratch
   always_ff @(posedge clock) begin
      if (accept && (req_chan.req_type == REQ_LOAD)) begin
         opnd_ff[req_chan.elem_index] <= req_chan.elem_value;
      end
      if (mac_res.valid) begin
         scratch_ff[mac_res.idx] <= mac_value;
      end
   end

   // stack memory for the levels below the top
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_wr_addr] <= top_q;
      end
      mem_q_ff <= stack_mem[mem_rd_addr];
   end

   // result channel
   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.status    = out_status_ff;
   assign rsp_chan.out_index = out_index_ff;
   assign rsp_chan.out_value = out_value_ff;
   assign rsp_chan.last      = out_last_ff;

endmodule
